// ----- rtl/hts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, codes, weights and the quarter-wave sine generator for the
// harmonic tone synthesizer.
// ----------------------------------------------------------------------------
package hts_pkg;

   // Fixed field widths.
   localparam int unsigned FREQ_BITS   = 32;
   localparam int unsigned TIMBRE_BITS = 2;
   localparam int unsigned INDEX_BITS  = 32;
   localparam int unsigned AMP_BITS    = 15;
   localparam int unsigned ROM_BITS    = 15;
   localparam int unsigned SINE_BITS   = 16;
   localparam int unsigned WEIGHT_BITS = 16;
   localparam int unsigned MIX_BITS    = 32;
   localparam int unsigned SCALED_BITS = 48;
   localparam int unsigned MUL_BITS    = 33;
   localparam int unsigned FRAC_BITS   = 30;
   localparam int unsigned HARMONICS   = 3;
   localparam int unsigned HARM_BITS   = 2;

   localparam logic [AMP_BITS-1:0] AMP_RESET = 15'd2000;

   // Timbre codes.
   localparam logic [TIMBRE_BITS-1:0] TIMBRE_PURE  = 2'd0;
   localparam logic [TIMBRE_BITS-1:0] TIMBRE_ORGAN = 2'd1;
   localparam logic [TIMBRE_BITS-1:0] TIMBRE_RETRO = 2'd2;

   // Datapath operation codes issued by the sequencer.
   localparam int unsigned OP_BITS = 3;
   localparam logic [OP_BITS-1:0] OP_NONE  = 3'd0;
   localparam logic [OP_BITS-1:0] OP_BASE  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_ADDR  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_ROM   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_MAC   = 3'd4;
   localparam logic [OP_BITS-1:0] OP_SCALE = 3'd5;
   localparam logic [OP_BITS-1:0] OP_FINAL = 3'd6;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      logic                 accept;
      logic [OP_BITS-1:0]   op;
      logic [HARM_BITS-1:0] harm;
   } ctrl_type;

   // Horner divisors of the sine series, used only at elaboration.
   localparam longint unsigned HORNER_DIV [6] = '{156, 110, 72, 42, 20, 6};
   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Q1.15 weight of one harmonic for a timbre. Unused code three is pure sine.
   function automatic logic [WEIGHT_BITS-1:0] harm_weight(
      input logic [TIMBRE_BITS-1:0] timbre,
      input logic [HARM_BITS-1:0]   harm
   );
      logic [WEIGHT_BITS-1:0] w;
      case (timbre)
         TIMBRE_ORGAN: begin
            case (harm)
               2'd0:    w = 16'd16384;
               2'd1:    w = 16'd3277;
               default: w = 16'd13107;
            endcase
         end
         TIMBRE_RETRO: begin
            case (harm)
               2'd0:    w = 16'd3277;
               2'd1:    w = 16'd6554;
               default: w = 16'd22938;
            endcase
         end
         default: begin
            w = (harm == '0) ? 16'd32768 : 16'd0;
         end
      endcase
      return w;
   endfunction

   // Quarter-wave table entry k of a table with 2^log2d steps, unsigned Q0.15.
   // A Q30 Taylor series in Horner form, rounded half up and capped.
   function automatic logic [ROM_BITS-1:0] qsine(
      input int unsigned k,
      input int unsigned log2d
   );
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned d;
      longint unsigned s;
      longint unsigned v;
      x  = (HALF_PI_Q30 * 64'(k)) >> log2d;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int i = 0; i < 6; i++) begin
         d = ((x2 * t) >> 30) / HORNER_DIV[i];
         t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
      end
      s = (x * t) >> 30;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[ROM_BITS-1:0];
   endfunction

endpackage

// ----- rtl/hts_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_stream_if
// Valid/ready channels of the synthesizer: tick requests in, samples out.
// ----------------------------------------------------------------------------
interface hts_req_if;
   logic                             valid;
   logic                             ready;
   logic [hts_pkg::FREQ_BITS-1:0]    freq_step;
   logic [hts_pkg::TIMBRE_BITS-1:0]  timbre;
   logic                             note_last;

   modport source (output valid, output freq_step, output timbre, output note_last,
                   input ready);
   modport sink   (input valid, input freq_step, input timbre, input note_last,
                   output ready);
endinterface

interface hts_rsp_if #(
   parameter int unsigned SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          sample_last;

   modport source (output valid, output sample, output sample_last, input ready);
   modport sink   (input valid, input sample, input sample_last, output ready);
endinterface

// ----- rtl/hts_sine_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_sine_rom
// Quarter-wave sine table, entries 0 to TABLE_DEPTH inclusive, registered read.
// ----------------------------------------------------------------------------
module hts_sine_rom #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic [$clog2(TABLE_DEPTH):0]        rd_addr,
   output logic [hts_pkg::ROM_BITS-1:0]        rd_data
);

   localparam int unsigned LOG2D = $clog2(TABLE_DEPTH);

   logic [hts_pkg::ROM_BITS-1:0] rom_mem [TABLE_DEPTH+1];
   logic [hts_pkg::ROM_BITS-1:0] rd_data_ff;

   // Table contents are worked out at elaboration.
   for (genvar k = 0; k <= TABLE_DEPTH; k++) begin : g_entry
      localparam logic [hts_pkg::ROM_BITS-1:0] ENTRY = hts_pkg::qsine(k, LOG2D);
      assign rom_mem[k] = ENTRY;
   end

   // Synchronous read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= rom_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/hts_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_sequencer
// Steps the shared datapath through one tick: index product, then address,
// table read and multiply-accumulate per harmonic, then amplitude scaling and the output write.
// ----------------------------------------------------------------------------
module hts_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              out_free,
   output logic              req_ready,
   output hts_pkg::ctrl_type ctrl
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BASE  = 3'd1;
   localparam logic [2:0] S_ADDR  = 3'd2;
   localparam logic [2:0] S_ROM   = 3'd3;
   localparam logic [2:0] S_MAC   = 3'd4;
   localparam logic [2:0] S_SCALE = 3'd5;
   localparam logic [2:0] S_FINAL = 3'd6;

   localparam logic [hts_pkg::HARM_BITS-1:0] LAST_HARM =
      hts_pkg::HARM_BITS'(hts_pkg::HARMONICS - 1);

   logic [2:0]                   state_ff, state_in;
   logic [hts_pkg::HARM_BITS-1:0] harm_ff, harm_in;

   // Next state and the operation issued in the current state.
   always_comb begin
      state_in    = state_ff;
      harm_in     = harm_ff;
      ctrl        = '0;
      ctrl.harm   = harm_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.accept = 1'b1;
               harm_in     = '0;
               state_in    = S_BASE;
            end
         end
         S_BASE: begin
            ctrl.op  = hts_pkg::OP_BASE;
            state_in = S_ADDR;
         end
         S_ADDR: begin
            ctrl.op  = hts_pkg::OP_ADDR;
            state_in = S_ROM;
         end
         S_ROM: begin
            ctrl.op  = hts_pkg::OP_ROM;
            state_in = S_MAC;
         end
         S_MAC: begin
            ctrl.op = hts_pkg::OP_MAC;
            if (harm_ff == LAST_HARM) begin
               state_in = S_SCALE;
            end else begin
               harm_in  = harm_ff + 1'b1;
               state_in = S_ADDR;
            end
         end
         S_SCALE: begin
            ctrl.op  = hts_pkg::OP_SCALE;
            state_in = S_FINAL;
         end
         S_FINAL: begin
            // Hold until the output register can take the new sample.
            if (out_free) begin
               ctrl.op  = hts_pkg::OP_FINAL;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         harm_ff  <= '0;
      end else begin
         state_ff <= state_in;
         harm_ff  <= harm_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// ----- rtl/hts_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_datapath
// Shared signed multiplier with its operand registers: phase generation,
// harmonic mix, amplitude scaling, truncation, saturation and the output register.
// ----------------------------------------------------------------------------
module hts_datapath #(
   parameter int unsigned PHASE_BITS  = 32,
   parameter int unsigned TABLE_DEPTH = 1024,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  hts_pkg::ctrl_type                  ctrl,
   input  logic [hts_pkg::FREQ_BITS-1:0]      req_freq_step,
   input  logic [hts_pkg::TIMBRE_BITS-1:0]    req_timbre,
   input  logic                               req_note_last,
   input  logic                               csr_wr_en,
   input  logic [hts_pkg::AMP_BITS-1:0]       csr_wr_data,
   input  logic [hts_pkg::ROM_BITS-1:0]       rom_data,
   output logic [$clog2(TABLE_DEPTH):0]       rom_addr,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample,
   output logic                               rsp_sample_last,
   output logic                               out_free
);

   localparam int unsigned LOG2D     = $clog2(TABLE_DEPTH);
   localparam int unsigned ADDR_BITS = LOG2D + 1;
   localparam int unsigned MB        = hts_pkg::MUL_BITS;
   localparam int unsigned SB        = hts_pkg::SCALED_BITS;

   localparam logic signed [SB-1:0] ROUND_BIAS =
      SB'((64'd1 << hts_pkg::FRAC_BITS) - 64'd1);
   localparam logic signed [SB-1:0] SAT_MAX = SB'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [SB-1:0] SAT_MIN = -SAT_MAX - SB'(1);

   // Item and state registers.
   logic [hts_pkg::FREQ_BITS-1:0]    step_ff, step_in;
   logic [hts_pkg::TIMBRE_BITS-1:0]  timbre_ff, timbre_in;
   logic                             last_ff, last_in;
   logic [hts_pkg::INDEX_BITS-1:0]   idx_ff, idx_in;
   logic [hts_pkg::AMP_BITS-1:0]     amp_ff, amp_in;
   logic [PHASE_BITS-1:0]            base_ff, base_in;
   logic [PHASE_BITS-1:0]            phase_ff, phase_in;
   logic [ADDR_BITS-1:0]             addr_ff, addr_in;
   logic                             neg_ff, neg_in;
   logic signed [hts_pkg::MIX_BITS-1:0] mix_ff, mix_in;
   logic signed [SB-1:0]             scaled_ff, scaled_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]    rsp_sample_ff, rsp_sample_in;
   logic                             rsp_last_ff, rsp_last_in;

   // Shared multiplier.
   logic signed [MB-1:0]             mul_a;
   logic signed [MB-1:0]             mul_b;
   logic signed [2*MB-1:0]           mul_p;

   logic [hts_pkg::WEIGHT_BITS-1:0]  weight;
   logic signed [hts_pkg::SINE_BITS-1:0] sine_pos;
   logic signed [hts_pkg::SINE_BITS-1:0] sine_val;
   logic [1:0]                       quad;
   logic [LOG2D-1:0]                 off;
   logic signed [SB-1:0]             biased;
   logic signed [SB-1:0]             quot;
   logic signed [SB-1:0]             sat;

   assign weight   = hts_pkg::harm_weight(timbre_ff, ctrl.harm);
   assign sine_pos = $signed({1'b0, rom_data});
   assign sine_val = neg_ff ? -sine_pos : sine_pos;

   // Operand selection for the one multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.op)
         hts_pkg::OP_BASE: begin
            mul_a = $signed({1'b0, idx_ff});
            mul_b = $signed({1'b0, step_ff});
         end
         hts_pkg::OP_MAC: begin
            mul_a = $signed({{(MB - hts_pkg::WEIGHT_BITS){1'b0}}, weight});
            mul_b = MB'(sine_val);
         end
         hts_pkg::OP_SCALE: begin
            mul_a = MB'(mix_ff);
            mul_b = $signed({{(MB - hts_pkg::AMP_BITS){1'b0}}, amp_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Table position of the current phase: quadrant and offset.
   assign quad = phase_ff[PHASE_BITS-1 -: 2];
   assign off  = phase_ff[PHASE_BITS-3 -: LOG2D];

   // Division by 2^30 truncating toward zero, then saturation.
   always_comb begin
      biased = scaled_ff + (scaled_ff[SB-1] ? ROUND_BIAS : '0);
      quot   = biased >>> hts_pkg::FRAC_BITS;
      if (quot > SAT_MAX) begin
         sat = SAT_MAX;
      end else if (quot < SAT_MIN) begin
         sat = SAT_MIN;
      end else begin
         sat = quot;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next values of all registers.
   always_comb begin
      step_in       = step_ff;
      timbre_in     = timbre_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      amp_in        = csr_wr_en ? csr_wr_data : amp_ff;
      base_in       = base_ff;
      phase_in      = phase_ff;
      addr_in       = addr_ff;
      neg_in        = neg_ff;
      mix_in        = mix_ff;
      scaled_in     = scaled_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (ctrl.accept) begin
         step_in   = req_freq_step;
         timbre_in = req_timbre;
         last_in   = req_note_last;
         mix_in    = '0;
      end
      case (ctrl.op)
         hts_pkg::OP_BASE: begin
            // The first harmonic's phase is the base phase itself.
            base_in  = mul_p[PHASE_BITS-1:0];
            phase_in = mul_p[PHASE_BITS-1:0];
            idx_in   = idx_ff + 1'b1;
         end
         hts_pkg::OP_ADDR: begin
            addr_in = quad[0] ? ADDR_BITS'(TABLE_DEPTH) - {1'b0, off} : {1'b0, off};
            neg_in  = quad[1];
         end
         hts_pkg::OP_MAC: begin
            mix_in   = mix_ff + $signed(mul_p[hts_pkg::MIX_BITS-1:0]);
            phase_in = phase_ff + base_ff;
         end
         hts_pkg::OP_SCALE: begin
            scaled_in = $signed(mul_p[SB-1:0]);
         end
         hts_pkg::OP_FINAL: begin
            rsp_valid_in  = 1'b1;
            rsp_sample_in = sat[SAMPLE_BITS-1:0];
            rsp_last_in   = last_ff;
         end
         default: begin
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         amp_ff       <= hts_pkg::AMP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         amp_ff       <= amp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      timbre_ff     <= timbre_in;
      last_ff       <= last_in;
      base_ff       <= base_in;
      phase_ff      <= phase_in;
      addr_ff       <= addr_in;
      neg_ff        <= neg_in;
      mix_ff        <= mix_in;
      scaled_ff     <= scaled_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rom_addr        = addr_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_sample_last = rsp_last_ff;

endmodule

// ----- rtl/harmonic_tone_synth_top.sv -----
`timescale 1ns / 1ps
// A request is taken only while idle; the tick then steps through the index product, three
// weighted harmonics and amplitude scaling on the single shared multiplier, with one table read
// per harmonic, and its sample enters the output register once that register is free.
// A response waiting in the output register does not block the next request.
// Reset (synchronous): sample index cleared, amplitude set to 2000, no clearing pass.
// ----------------------------------------------------------------------------
// harmonic_tone_synth_top
// Additive synthesizer of up to three harmonics from a quarter-wave sine table.
// ----------------------------------------------------------------------------
module harmonic_tone_synth_top #(
   parameter int unsigned PHASE_BITS       = 32,
   parameter int unsigned SINE_TABLE_DEPTH = 1024,
   parameter int unsigned SAMPLE_BITS      = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   hts_req_if.sink                      req_chan,
   hts_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [hts_pkg::AMP_BITS-1:0] csr_wr_data
);

   hts_pkg::ctrl_type                  ctrl;
   logic                               out_free;
   logic [$clog2(SINE_TABLE_DEPTH):0]  rom_addr;
   logic [hts_pkg::ROM_BITS-1:0]       rom_data;

   // Sequencer: owns the request handshake.
   hts_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .out_free  (out_free),
      .req_ready (req_chan.ready),
      .ctrl      (ctrl)
   );

   // Shared arithmetic and output register.
   hts_datapath #(
      .PHASE_BITS  (PHASE_BITS),
      .TABLE_DEPTH (SINE_TABLE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_freq_step   (req_chan.freq_step),
      .req_timbre      (req_chan.timbre),
      .req_note_last   (req_chan.note_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rom_data        (rom_data),
      .rom_addr        (rom_addr),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_sample      (rsp_chan.sample),
      .rsp_sample_last (rsp_chan.sample_last),
      .out_free        (out_free)
   );

   // Quarter-wave table.
   hts_sine_rom #(
      .TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

endmodule

// ----- rtl/hts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_checker
// Port-level checks of the synthesizer's sequencing and response channel.
// ----------------------------------------------------------------------------
module hts_checker #(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_sample,
   input logic                   rsp_sample_last
);

   // A stalled response beat keeps its valid and payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample)
                                  && $stable(rsp_sample_last))
      else $error("response beat changed while stalled");

   // Once a request beat is taken, the block stays busy and drops ready while the tick runs.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("request accepted while a tick was still in progress");

   // A new response appears only at the end of a tick, never while idle.
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised without a tick in progress");

   // Reset leaves the block idle with no pending response.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind harmonic_tone_synth_top hts_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_hts_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_sample      (rsp_chan.sample),
   .rsp_sample_last (rsp_chan.sample_last)
);
